// ===== design/segment_box_clip_3d_defines.svh =====
// ----------------------------------------------------------------------------
// segment_box_clip_3d_defines
// Assertion macros for the segment box clipper.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_CLIP_3D_DEFINES_SVH
`define SEGMENT_BOX_CLIP_3D_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m");
`define SBC_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m");
`else
`define SBC_ASSERT(label, clk, rst_n, prop)
`define SBC_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== design/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Types, widths and helpers shared by the segment box clipper.
// ----------------------------------------------------------------------------
package sbc_pkg;
    localparam int CW    = 24;
    localparam int FB    = 16;
    localparam int TW    = FB + 1;
    localparam int QW    = FB + 3;
    localparam int DW    = CW + 1;
    localparam int NTEST = 6;
    // Quotient bits resolved by the division steps; larger quotients only saturate
    localparam int QB    = FB + 2;

    localparam logic signed [QW-1:0] T_ZERO = '0;
    localparam logic signed [QW-1:0] T_ONE  = QW'(1) << FB;
    localparam logic [QW-1:0] CAP_POS = QW'(2) << FB;
    localparam logic [QW-1:0] CAP_NEG = (QW'(1) << FB) + QW'(1);

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
        logic signed [CW-1:0] box_min_x;
        logic signed [CW-1:0] box_min_y;
        logic signed [CW-1:0] box_min_z;
        logic signed [CW-1:0] box_max_x;
        logic signed [CW-1:0] box_max_y;
        logic signed [CW-1:0] box_max_z;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic [TW-1:0]        t_enter;
        logic [TW-1:0]        t_exit;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_start_z;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
        logic signed [CW-1:0] clip_end_z;
    } t_out;

    // State handed from cell to cell down the chain
    typedef struct packed {
        logic                 vld;
        logic                 ok;
        logic signed [QW-1:0] t0;
        logic signed [QW-1:0] t1;
        logic signed [CW-1:0] s_x;
        logic signed [CW-1:0] s_y;
        logic signed [CW-1:0] s_z;
        logic signed [CW-1:0] e_x;
        logic signed [CW-1:0] e_y;
        logic signed [CW-1:0] e_z;
        logic signed [CW-1:0] lo_x;
        logic signed [CW-1:0] lo_y;
        logic signed [CW-1:0] lo_z;
        logic signed [CW-1:0] hi_x;
        logic signed [CW-1:0] hi_y;
        logic signed [CW-1:0] hi_z;
    } t_tok;

    // Divider state carried alongside a token
    typedef struct packed {
        logic            act;
        logic            neg;
        logic            pneg;
        logic            sat;
        logic            ovf;
        logic [1:0]      nb;
        logic [DW-1:0]   b;
        logic [DW-1:0]   r;
        logic [QW-1:0]   quo;
    } t_div;
endpackage

// ===== design/sbc_div_cell.sv =====
// ----------------------------------------------------------------------------
// sbc_div_cell
// One restoring-division step of the boundary quotient; passes the item on.
// ----------------------------------------------------------------------------
module sbc_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbc_pkg::t_tok i_tok,
    input  sbc_pkg::t_div i_div,
    input  logic [sbc_pkg::QW-1:0] i_bit_pos,
    input  logic          i_num_bit,
    output sbc_pkg::t_tok o_tok,
    output sbc_pkg::t_div o_div
);
    import sbc_pkg::*;

    t_tok r_tok;
    t_div r_div, n_div;
    logic [DW:0] w_trial;

    always_comb begin
        n_div   = i_div;
        w_trial = {i_div.r, i_num_bit};
        if (w_trial >= {1'b0, i_div.b}) begin
            n_div.r   = DW'(w_trial - {1'b0, i_div.b});
            n_div.quo = i_div.quo | i_bit_pos;
        end else begin
            n_div.r   = w_trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok[$bits(t_tok)-2:0] <= i_tok[$bits(t_tok)-2:0];
        r_div <= n_div;
    end

    assign o_tok = r_tok;
    assign o_div = r_div;
endmodule

// ===== design/sbc_edge_cell.sv =====
// ----------------------------------------------------------------------------
// sbc_edge_cell
// One Liang-Barsky boundary test: a chain of division steps, then the update.
// ----------------------------------------------------------------------------
module sbc_edge_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_axis,
    input  logic          i_max_side,
    input  sbc_pkg::t_tok i_tok,
    output sbc_pkg::t_tok o_tok
);
    import sbc_pkg::*;

    logic signed [CW-1:0] w_s, w_e, w_lo, w_hi;
    logic signed [DW:0]   w_p, w_q;
    logic [DW:0]          w_a;
    logic [DW-1:0]        w_b;
    t_tok r_tok0;
    t_div r_div0;
    t_tok w_tok [QB+1];
    t_div w_div [QB+1];
    logic [QW-1:0]        w_cap, w_m;
    logic signed [QW-1:0] w_t;
    t_tok n_tok;
    t_div w_d;
    t_tok r_tokf;

    always_comb begin
        case (i_axis)
            3'd0: begin w_s = i_tok.s_x; w_e = i_tok.e_x; w_lo = i_tok.lo_x; w_hi = i_tok.hi_x; end
            3'd1: begin w_s = i_tok.s_y; w_e = i_tok.e_y; w_lo = i_tok.lo_y; w_hi = i_tok.hi_y; end
            default: begin
                w_s = i_tok.s_z; w_e = i_tok.e_z; w_lo = i_tok.lo_z; w_hi = i_tok.hi_z;
            end
        endcase
        if (i_max_side) begin
            w_p = (DW+1)'(w_e) - (DW+1)'(w_s);
            w_q = (DW+1)'(w_hi) - (DW+1)'(w_s);
        end else begin
            w_p = (DW+1)'(w_s) - (DW+1)'(w_e);
            w_q = (DW+1)'(w_s) - (DW+1)'(w_lo);
        end
        w_a = w_q[DW] ? (DW+1)'(-w_q) : (DW+1)'(w_q);
        w_b = w_p[DW] ? DW'(-w_p) : DW'(w_p);
    end

    // Quotient of (a << FB) / b: saturate when a >= 4b, else resolve QB bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.vld <= 1'b0;
        end else begin
            r_tok0.vld <= i_tok.vld;
        end
        r_tok0[$bits(t_tok)-2:0] <= i_tok[$bits(t_tok)-2:0];
        r_div0.act  <= (w_p != '0);
        r_div0.neg  <= w_q[DW] ^ w_p[DW];
        r_div0.pneg <= w_p[DW];
        r_div0.sat  <= (w_p == '0) && w_q[DW];
        r_div0.ovf  <= ({1'b0, w_a} >= {w_b, 2'b00});
        r_div0.nb   <= w_a[1:0];
        r_div0.b    <= w_b;
        r_div0.r    <= DW'(w_a >> 2);
        r_div0.quo  <= '0;
    end

    assign w_tok[0] = r_tok0;
    assign w_div[0] = r_div0;

    genvar g;
    generate
        for (g = 0; g < QB; g++) begin : g_step
            localparam int BP = QB - 1 - g;
            logic w_nbit;
            assign w_nbit = (BP == FB + 1) ? w_div[g].nb[1] :
                            (BP == FB)     ? w_div[g].nb[0] : 1'b0;
            sbc_div_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_tok     (w_tok[g]),
                .i_div     (w_div[g]),
                .i_bit_pos (QW'(1) << BP),
                .i_num_bit (w_nbit),
                .o_tok     (w_tok[g+1]),
                .o_div     (w_div[g+1])
            );
        end
    endgenerate

    // Clamp and update the parameters
    always_comb begin
        w_d   = w_div[QB];
        w_cap = w_d.neg ? CAP_NEG : CAP_POS;
        w_m   = (w_d.ovf || (w_d.quo > w_cap)) ? w_cap : w_d.quo;
        w_t   = w_d.neg ? -$signed(w_m) : $signed(w_m);
        n_tok = w_tok[QB];
        if (n_tok.ok) begin
            if (!w_d.act) begin
                if (w_d.sat) begin
                    n_tok.ok = 1'b0;
                end
            end else if (w_d.pneg) begin
                if (w_t > n_tok.t1) begin
                    n_tok.ok = 1'b0;
                end else if (w_t > n_tok.t0) begin
                    n_tok.t0 = w_t;
                end
            end else begin
                if (w_t < n_tok.t0) begin
                    n_tok.ok = 1'b0;
                end else if (w_t < n_tok.t1) begin
                    n_tok.t1 = w_t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokf.vld <= 1'b0;
        end else begin
            r_tokf.vld <= n_tok.vld;
        end
        r_tokf[$bits(t_tok)-2:0] <= n_tok[$bits(t_tok)-2:0];
    end

    assign o_tok = r_tokf;
endmodule

// ===== design/sbc_lerp.sv =====
// ----------------------------------------------------------------------------
// sbc_lerp
// Clipped endpoint: start + t*D (or the end point when i_use is low), magnitude truncated, two registered stages.
// ----------------------------------------------------------------------------
module sbc_lerp (
    input  logic                        i_clk,
    input  logic signed [sbc_pkg::CW-1:0] i_s,
    input  logic signed [sbc_pkg::CW-1:0] i_e,
    input  logic signed [sbc_pkg::QW-1:0] i_t,
    input  logic                        i_use,
    output logic signed [sbc_pkg::CW-1:0] o_v
);
    import sbc_pkg::*;

    logic signed [DW-1:0] w_d;
    logic [DW-1:0]        w_m;
    logic [DW+TW-1:0]     r_prod;
    logic                 r_neg, r_use;
    logic signed [CW-1:0] r_s, r_e;
    logic [DW-1:0]        w_inc;

    assign w_d = DW'(i_e) - DW'(i_s);
    assign w_m = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);

    always_ff @(posedge i_clk) begin
        r_prod <= w_m * TW'(i_t);
        r_neg  <= w_d[DW-1];
        r_use  <= i_use;
        r_s    <= i_s;
        r_e    <= i_e;
    end

    assign w_inc = DW'(r_prod >> FB);

    always_ff @(posedge i_clk) begin
        if (!r_use) begin
            o_v <= r_e;
        end else if (r_neg) begin
            o_v <= CW'(DW'(r_s) - w_inc);
        end else begin
            o_v <= CW'(DW'(r_s) + w_inc);
        end
    end
endmodule

// ===== design/segment_box_clip_3d.sv =====
// ----------------------------------------------------------------------------
// segment_box_clip_3d
// Liang-Barsky clip of a 3D segment against an axis-aligned box.
// ----------------------------------------------------------------------------
// Fully pipelined: one item may start every cycle (busy stays low). Each
// result appears on o_res with o_strobe high for one cycle, after the
// item has passed the six boundary-test cells in a row, each an input
// stage, eighteen one-bit restoring-division steps and an update stage,
// and then the two interpolation stages. The receiver cannot stall the
// block: every result must be taken in the cycle it appears.
// ----------------------------------------------------------------------------
`include "segment_box_clip_3d_defines.svh"

module segment_box_clip_3d (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sbc_pkg::t_in  i_item,
    output logic          o_strobe,
    output sbc_pkg::t_out o_res
);
    import sbc_pkg::*;

    t_tok w_tok [NTEST+1];

    always_comb begin
        w_tok[0].vld  = start && !busy;
        w_tok[0].ok   = 1'b1;
        w_tok[0].t0   = T_ZERO;
        w_tok[0].t1   = T_ONE;
        w_tok[0].s_x  = i_item.start_x;
        w_tok[0].s_y  = i_item.start_y;
        w_tok[0].s_z  = i_item.start_z;
        w_tok[0].e_x  = i_item.end_x;
        w_tok[0].e_y  = i_item.end_y;
        w_tok[0].e_z  = i_item.end_z;
        w_tok[0].lo_x = i_item.box_min_x;
        w_tok[0].lo_y = i_item.box_min_y;
        w_tok[0].lo_z = i_item.box_min_z;
        w_tok[0].hi_x = i_item.box_max_x;
        w_tok[0].hi_y = i_item.box_max_y;
        w_tok[0].hi_z = i_item.box_max_z;
    end

    assign busy = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NTEST; g++) begin : g_edge
            sbc_edge_cell u_edge (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_axis     (3'(g / 2)),
                .i_max_side (1'((g % 2) == 1)),
                .i_tok      (w_tok[g]),
                .o_tok      (w_tok[g+1])
            );
        end
    endgenerate

    t_tok w_f;
    logic w_u0, w_u1;
    logic signed [CW-1:0] w_cs [3];
    logic signed [CW-1:0] w_ce [3];
    logic signed [CW-1:0] w_sv [3];
    logic signed [CW-1:0] w_ev [3];
    logic r_v1, r_v2, r_ok1, r_ok2;
    logic [TW-1:0] r_t01, r_t02, r_t11, r_t12;

    assign w_f   = w_tok[NTEST];
    assign w_u0  = w_f.t0 > T_ZERO;
    assign w_u1  = w_f.t1 < T_ONE;
    assign w_sv[0] = w_f.s_x;
    assign w_sv[1] = w_f.s_y;
    assign w_sv[2] = w_f.s_z;
    assign w_ev[0] = w_f.e_x;
    assign w_ev[1] = w_f.e_y;
    assign w_ev[2] = w_f.e_z;

    generate
        for (g = 0; g < 3; g++) begin : g_lerp
            sbc_lerp u_ls (
                .i_clk (i_clk), .i_s (w_sv[g]), .i_e (w_ev[g]),
                .i_t (w_u0 ? w_f.t0 : T_ZERO), .i_use (1'b1), .o_v (w_cs[g])
            );
            sbc_lerp u_le (
                .i_clk (i_clk), .i_s (w_sv[g]), .i_e (w_ev[g]),
                .i_t (w_f.t1), .i_use (w_u1), .o_v (w_ce[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_f.vld;
            r_v2 <= r_v1;
        end
        r_ok1 <= w_f.ok;
        r_ok2 <= r_ok1;
        r_t01 <= TW'(w_f.t0);
        r_t02 <= r_t01;
        r_t11 <= TW'(w_f.t1);
        r_t12 <= r_t11;
    end

    always_comb begin
        o_strobe = r_v2;
        o_res    = '0;
        if (r_ok2) begin
            o_res.hit          = 1'b1;
            o_res.t_enter      = r_t02;
            o_res.t_exit       = r_t12;
            o_res.clip_start_x = w_cs[0];
            o_res.clip_start_y = w_cs[1];
            o_res.clip_start_z = w_cs[2];
            o_res.clip_end_x   = w_ce[0];
            o_res.clip_end_y   = w_ce[1];
            o_res.clip_end_z   = w_ce[2];
        end
    end

    `SBC_ASSERT(a_never_busy, i_clk, i_rst_n, !busy)
    `SBC_ASSERT(a_strobe_follows, i_clk, i_rst_n, o_strobe |-> $past(r_v1))
    `SBC_ASSERT(a_t_order, i_clk, i_rst_n, (o_strobe && o_res.hit) |-> (o_res.t_enter <= o_res.t_exit))
    `SBC_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> !r_v1)
endmodule

// ===== test/segment_box_clip_3d_tb.sv =====
// ----------------------------------------------------------------------------
// segment_box_clip_3d_tb
// Self-checking bench for the 3D segment box clipper: directed corner cases
// then random segments, predicted in the bench and compared field by field.
// ----------------------------------------------------------------------------
module segment_box_clip_3d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbc_pkg::*;

    localparam longint T_UNIT   = longint'(1) << FB;
    localparam int     LATENCY  = 400;
    localparam longint MAX_CYC  = 2000000;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_item;
    logic  o_strobe;
    t_out  o_res;

    t_in    pending_items[$];
    t_out   expected_clips[$];
    int     idle_pct;
    bit     failed;
    longint cycle_count;

    segment_box_clip_3d i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint edge_ratio(longint q, longint p);
        bit     neg;
        longint a, b, cap, ip, r, frac, m;
        neg  = (q < 0) != (p < 0);
        a    = (q < 0) ? -q : q;
        b    = (p < 0) ? -p : p;
        cap  = neg ? T_UNIT + 1 : T_UNIT * 2;
        ip   = a / b;
        r    = a % b;
        frac = 0;
        if (ip > cap) begin
            m = cap;
        end else begin
            for (int i = 0; i < FB; i++) begin
                r    = r << 1;
                frac = frac << 1;
                if (r >= b) begin
                    r    = r - b;
                    frac = frac | 1;
                end
            end
            m = (ip << FB) | frac;
            if (m > cap) m = cap;
        end
        return neg ? -m : m;
    endfunction

    function automatic bit boundary_pass(longint p, longint q, ref longint t0,
                                         ref longint t1);
        longint t;
        if (p < 0) begin
            t = edge_ratio(q, p);
            if (t > t1) return 0;
            if (t > t0) t0 = t;
        end else if (p > 0) begin
            t = edge_ratio(q, p);
            if (t < t0) return 0;
            if (t < t1) t1 = t;
        end else if (q < 0) begin
            return 0;
        end
        return 1;
    endfunction

    function automatic longint interp(longint s, longint d, longint t);
        longint m, prod;
        m    = (d < 0) ? -d : d;
        prod = (m >> FB) * t + (((m & (T_UNIT - 1)) * t) >> FB);
        return (d < 0) ? s - prod : s + prod;
    endfunction

    function automatic t_out clip_segment(t_in it);
        longint s[3], e[3], lo[3], hi[3], d[3], t0, t1, a, b;
        bit     ok;
        t_out   res;
        logic [CW-1:0] ca[3], cb[3];
        s  = '{longint'(it.start_x), longint'(it.start_y), longint'(it.start_z)};
        e  = '{longint'(it.end_x), longint'(it.end_y), longint'(it.end_z)};
        lo = '{longint'(it.box_min_x), longint'(it.box_min_y), longint'(it.box_min_z)};
        hi = '{longint'(it.box_max_x), longint'(it.box_max_y), longint'(it.box_max_z)};
        t0 = 0;
        t1 = T_UNIT;
        ok = 1;
        res = '0;
        for (int k = 0; k < 3; k++) d[k] = e[k] - s[k];
        for (int k = 0; k < 3 && ok; k++) begin
            ok = boundary_pass(-d[k], s[k] - lo[k], t0, t1);
            if (ok) ok = boundary_pass(d[k], hi[k] - s[k], t0, t1);
        end
        if (!ok) return res;
        for (int k = 0; k < 3; k++) begin
            a = (t0 > 0) ? interp(s[k], d[k], t0) : s[k];
            b = (t1 < T_UNIT) ? interp(s[k], d[k], t1) : e[k];
            ca[k] = a[CW-1:0];
            cb[k] = b[CW-1:0];
        end
        res.hit          = 1'b1;
        res.t_enter      = t0[TW-1:0];
        res.t_exit       = t1[TW-1:0];
        res.clip_start_x = ca[0];
        res.clip_start_y = ca[1];
        res.clip_start_z = ca[2];
        res.clip_end_x   = cb[0];
        res.clip_end_y   = cb[1];
        res.clip_end_z   = cb[2];
        return res;
    endfunction

    function automatic logic [CW-1:0] rand_coord(int spread);
        case ($urandom_range(0, 5))
            0: return CW'($urandom);
            1: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    function automatic t_in rand_segment();
        t_in it;
        int  spread;
        logic [CW-1:0] a, b;
        spread = $urandom_range(0, 3) == 0 ? 4000000 : 2000;
        it.start_x = rand_coord(spread);
        it.start_y = rand_coord(spread);
        it.start_z = rand_coord(spread);
        it.end_x   = rand_coord(spread);
        it.end_y   = rand_coord(spread);
        it.end_z   = rand_coord(spread);
        a = rand_coord(spread); b = rand_coord(spread);
        {it.box_min_x, it.box_max_x} = ($signed(a) > $signed(b) && $urandom_range(0, 9) != 0)
                                       ? {b, a} : {a, b};
        a = rand_coord(spread); b = rand_coord(spread);
        {it.box_min_y, it.box_max_y} = ($signed(a) > $signed(b) && $urandom_range(0, 9) != 0)
                                       ? {b, a} : {a, b};
        a = rand_coord(spread); b = rand_coord(spread);
        {it.box_min_z, it.box_max_z} = ($signed(a) > $signed(b) && $urandom_range(0, 9) != 0)
                                       ? {b, a} : {a, b};
        if ($urandom_range(0, 9) == 0) begin
            it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
        end else if ($urandom_range(0, 9) == 0) begin
            it.end_y = it.start_y;
        end
        return it;
    endfunction

    function automatic t_in make_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                                         int lo, int hi);
        t_in it;
        it.start_x = CW'(sx); it.start_y = CW'(sy); it.start_z = CW'(sz);
        it.end_x   = CW'(ex); it.end_y   = CW'(ey); it.end_z   = CW'(ez);
        it.box_min_x = CW'(lo); it.box_min_y = CW'(lo); it.box_min_z = CW'(lo);
        it.box_max_x = CW'(hi); it.box_max_y = CW'(hi); it.box_max_z = CW'(hi);
        return it;
    endfunction

    logic took_item;

    always @(posedge i_clk) begin
        took_item    <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) expected_clips.push_back(clip_segment(i_item));
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took_item)) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end else begin
                start  <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_clips.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                failed = 1'b1;
            end else begin
                want = expected_clips.pop_front();
                if (o_res.hit !== want.hit)
                    $display("%0t: hit exp %0d got %0d", $time, want.hit, o_res.hit);
                if (o_res.t_enter !== want.t_enter)
                    $display("%0t: t_enter exp %0d got %0d", $time, want.t_enter,
                             o_res.t_enter);
                if (o_res.t_exit !== want.t_exit)
                    $display("%0t: t_exit exp %0d got %0d", $time, want.t_exit, o_res.t_exit);
                if (o_res.clip_start_x !== want.clip_start_x)
                    $display("%0t: clip_start_x exp %0d got %0d", $time,
                             want.clip_start_x, o_res.clip_start_x);
                if (o_res.clip_start_y !== want.clip_start_y)
                    $display("%0t: clip_start_y exp %0d got %0d", $time,
                             want.clip_start_y, o_res.clip_start_y);
                if (o_res.clip_start_z !== want.clip_start_z)
                    $display("%0t: clip_start_z exp %0d got %0d", $time,
                             want.clip_start_z, o_res.clip_start_z);
                if (o_res.clip_end_x !== want.clip_end_x)
                    $display("%0t: clip_end_x exp %0d got %0d", $time,
                             want.clip_end_x, o_res.clip_end_x);
                if (o_res.clip_end_y !== want.clip_end_y)
                    $display("%0t: clip_end_y exp %0d got %0d", $time,
                             want.clip_end_y, o_res.clip_end_y);
                if (o_res.clip_end_z !== want.clip_end_z)
                    $display("%0t: clip_end_z exp %0d got %0d", $time,
                             want.clip_end_z, o_res.clip_end_z);
                if (o_res !== want) failed = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || start) @(posedge i_clk);
        while (expected_clips.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in it;
        failed      = 1'b0;
        cycle_count = 0;
        idle_pct    = 0;
        start       = 1'b0;
        i_item      = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_items.push_back(make_segment(0, 0, 0, 256, 256, 256, -512, 512));
        pending_items.push_back(make_segment(-1024, 0, 0, 1024, 0, 0, -256, 256));
        pending_items.push_back(make_segment(-1024, -900, 300, 1024, 700, -300, -256, 256));
        pending_items.push_back(make_segment(1024, 1024, 1024, 2048, 2048, 2048, -256, 256));
        pending_items.push_back(make_segment(100, 100, 100, 100, 100, 100, -256, 256));
        pending_items.push_back(make_segment(1000, 100, 100, 1000, 100, 100, -256, 256));
        pending_items.push_back(make_segment(0, 0, 0, 10, 10, 10, 256, -256));
        pending_items.push_back(make_segment(-256, -256, -256, 256, 256, 256, -256, 256));
        pending_items.push_back(make_segment(-8388608, -8388608, -8388608,
                                             8388607, 8388607, 8388607, -8388608, 8388607));
        pending_items.push_back(make_segment(8388607, 8388607, 8388607,
                                             -8388608, -8388608, -8388608, -1, 1));
        pending_items.push_back(make_segment(-8388608, 0, 0, 8388607, 1, 1, -1, 0));
        pending_items.push_back(make_segment(0, 0, 0, 1, 0, 0, 2, 8388607));
        pending_items.push_back(make_segment(0, 0, 0, 3, 3, 3, 1, 2));
        pending_items.push_back(make_segment(5, 5, 5, -5, -5, -5, -8388608, 8388607));
        it = make_segment(0, 0, 0, 1000, -1000, 500, -300, 300);
        it.box_max_z = CW'(-301);
        pending_items.push_back(it);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 59 : (ph == 3) ? 30 : 0;
            for (int n = 0; n < 375; n++) begin
                pending_items.push_back(rand_segment());
                if (ph == 2 && n % 50 == 0) begin
                    pending_items.push_back(make_segment(0, 0, 0, 256, 256, 256, -512, 512));
                    drain();
                end
            end
            drain();
        end
        repeat (LATENCY) @(posedge i_clk);

        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
